>>> rtl/core/sine_cosine_tangent_series_defines.svh
// Assertion macros for the sine/cosine/tangent series block.
// Used by the top level only; needs a clock named clock and a reset named reset.
`ifndef SINE_COSINE_TANGENT_SERIES_DEFINES_SVH
`define SINE_COSINE_TANGENT_SERIES_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define SCT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define SCT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/core/sct_pkg.sv
// Shared types and constants for the sine/cosine/tangent series block.
// No dependencies; used by every module of the block.
package sct_pkg;

   // Operation codes
   localparam logic [1:0] OP_SINE      = 2'd0;
   localparam logic [1:0] OP_COSINE    = 2'd1;
   localparam logic [1:0] OP_TANGENT   = 2'd2;
   localparam logic [1:0] OP_COTANGENT = 2'd3;

   // Angle constants in Q24, on the 35-bit working angle
   localparam int X_W = 35;
   localparam logic signed [X_W-1:0] PI_Q      = 35'sd52707179;
   localparam logic signed [X_W-1:0] TWO_PI_Q  = 35'sd105414357;
   localparam logic signed [X_W-1:0] HALF_PI_Q = 35'sd26353589;

   localparam logic [3:0] TERM_COUNT_RESET = 4'd10;

   // Divider geometry
   localparam int DIV_NUM_W = 52;
   localparam int DIV_DEN_W = 27;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] angle;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               saturated;
      logic               divide_by_zero;
   } rsp_word_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_REDUCE,
      DP_CLEAR,
      DP_SQUARE,
      DP_SQ_DONE,
      DP_ACCUM,
      DP_MULT,
      DP_DIV_START,
      DP_TERM,
      DP_SINE_DONE,
      DP_QUOT_START,
      DP_QUOT_DONE
   } dp_op_type;

   typedef struct packed {
      dp_op_type  dp_op;
      logic       from_req;    // load angle from the request word
      logic       cos_arg;     // working on pi/2 - angle
      logic       final_sel;   // sine result is the response value
      logic       tan_sel;     // quotient is sine over cosine
      logic [3:0] k;           // series term index
   } dp_cmd_type;

   typedef struct packed {
      logic x_gt_pi;
      logic x_lt_neg_pi;
      logic x_eq_pi;
      logic div_done;
   } dp_stat_type;

   // Series divisor (2k)(2k+1)
   function automatic logic [8:0] series_div(input logic [3:0] k);
      logic [4:0] k2;
      logic [9:0] prod;
      begin
         k2   = {k, 1'b0};
         prod = 10'(k2) * 10'(k2 + 5'd1);
         series_div = prod[8:0];
      end
   endfunction

endpackage

>>> rtl/core/sct_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sct_pkg for its widths.
module sct_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sct_pkg::DIV_NUM_W-1:0]  num,
   input  logic [sct_pkg::DIV_DEN_W-1:0]  den,
   output logic                           done,
   output logic [sct_pkg::DIV_NUM_W-1:0]  quot
);
   localparam int NW = sct_pkg::DIV_NUM_W;
   localparam int DW = sct_pkg::DIV_DEN_W;
   localparam int CW = $clog2(NW);
   localparam logic [CW-1:0] LAST = CW'(NW - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] acc_ff, acc_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;

   logic [DW:0]   rem_sh;
   logic [DW+1:0] diff;
   logic          ge;

   // One trial subtract per cycle
   always_comb begin
      rem_sh = {rem_ff, acc_ff[NW-1]};
      diff   = {1'b0, rem_sh} - {2'b00, den_ff};
      ge     = ~diff[DW+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         acc_in = {acc_ff[NW-2:0], ge};
         rem_in = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = acc_ff;

endmodule

>>> rtl/core/sct_datapath.sv
// Datapath: range reduction, shared multiplier, series accumulator and quotient.
// Depends on sct_pkg and sct_divider; driven by sct_ctrl commands.
module sct_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  sct_pkg::dp_cmd_type   cmd,
   input  sct_pkg::req_word_type req_word,
   output sct_pkg::dp_stat_type  stat,
   output sct_pkg::rsp_word_type rsp_word
);
   localparam int XW = sct_pkg::X_W;
   localparam int NW = sct_pkg::DIV_NUM_W;
   localparam int DW = sct_pkg::DIV_DEN_W;

   logic signed [31:0]   angle_ff;
   logic signed [XW-1:0] x_ff;
   logic [29:0]          a28_ff;
   logic                 neg_ff;
   logic [31:0]          a2_ff;
   logic [31:0]          term_ff;
   logic [63:0]          prod_ff;
   logic signed [35:0]   sum_ff;
   logic signed [31:0]   s_ff, c_ff;
   logic                 qneg_ff, dz_ff, nz_ff, nneg_ff;
   sct_pkg::rsp_word_type res_ff;

   logic signed [31:0]   src_angle;
   logic signed [XW-1:0] src_ext, load_x;
   logic [XW-1:0]        x_abs;
   logic [29:0]          a28_c;
   logic [31:0]          mul_a, mul_b;
   logic [63:0]          sq_round, ser_round;
   logic [8:0]           cdiv;
   logic [35:0]          sum_abs, sum_rnd;
   logic [31:0]          r_mag;
   logic signed [31:0]   r_val;
   logic signed [31:0]   num_v, den_v;
   logic [31:0]          un32, ud32;
   logic [NW-1:0]        qnum;
   logic                 div_start, div_done;
   logic [NW-1:0]        div_num, div_quot;
   logic [DW-1:0]        div_den;
   logic [31:0]          q_lo;

   // Argument select and reduction compares
   always_comb begin
      src_angle = cmd.from_req ? req_word.angle : angle_ff;
      src_ext   = XW'(src_angle);
      load_x    = cmd.cos_arg ? (sct_pkg::HALF_PI_Q - src_ext) : src_ext;
      stat.x_gt_pi     = x_ff > sct_pkg::PI_Q;
      stat.x_lt_neg_pi = x_ff < -sct_pkg::PI_Q;
      stat.x_eq_pi     = x_ff == sct_pkg::PI_Q;
      stat.div_done    = div_done;
   end

   // Magnitude in Q4.28 and multiplier operands
   always_comb begin
      x_abs = x_ff[XW-1] ? XW'(-x_ff) : XW'(x_ff);
      a28_c = {x_abs[25:0], 4'b0000};
      if (cmd.dp_op == sct_pkg::DP_SQUARE) begin
         mul_a = {2'b00, a28_c};
         mul_b = {2'b00, a28_c};
      end else begin
         mul_a = term_ff;
         mul_b = a2_ff;
      end
      sq_round  = prod_ff + (64'd1 << 27);
      cdiv      = sct_pkg::series_div(cmd.k);
      ser_round = prod_ff + ({55'd0, cdiv} << 27);
   end

   // Q28 sum rounded to Q24, ties away from zero, sign of angle applied
   always_comb begin
      sum_abs = sum_ff[35] ? 36'(-sum_ff) : 36'(sum_ff);
      sum_rnd = sum_abs + 36'd8;
      r_mag   = sum_rnd[35:4];
      r_val   = (sum_ff[35] ^ neg_ff) ? -$signed(r_mag) : $signed(r_mag);
   end

   // Quotient operands: |num| * 2^24 + |den| / 2
   always_comb begin
      num_v = cmd.tan_sel ? s_ff : c_ff;
      den_v = cmd.tan_sel ? c_ff : s_ff;
      un32  = num_v[31] ? 32'(-num_v) : 32'(num_v);
      ud32  = den_v[31] ? 32'(-den_v) : 32'(den_v);
      qnum  = (NW'(un32[DW-1:0]) << 24) + NW'(ud32[DW-1:1]);
      q_lo  = div_quot[31:0];
   end

   // Divider launch
   always_comb begin
      div_start = 1'b0;
      div_num   = NW'(ser_round[63:28]);
      div_den   = DW'(cdiv);
      if (cmd.dp_op == sct_pkg::DP_DIV_START) begin
         div_start = 1'b1;
      end else if (cmd.dp_op == sct_pkg::DP_QUOT_START) begin
         div_start = 1'b1;
         div_num   = qnum;
         div_den   = ud32[DW-1:0];
      end
   end

   sct_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Datapath registers
   always_ff @(posedge clock) begin
      case (cmd.dp_op)
         sct_pkg::DP_LOAD: begin
            if (cmd.from_req) angle_ff <= req_word.angle;
            x_ff <= load_x;
         end
         sct_pkg::DP_REDUCE: begin
            if (stat.x_gt_pi) x_ff <= x_ff - sct_pkg::TWO_PI_Q;
            else              x_ff <= x_ff + sct_pkg::TWO_PI_Q;
         end
         sct_pkg::DP_CLEAR: begin
            sum_ff <= '0;
            neg_ff <= 1'b0;
         end
         sct_pkg::DP_SQUARE: begin
            a28_ff  <= a28_c;
            neg_ff  <= x_ff[XW-1];
            prod_ff <= mul_a * mul_b;
         end
         sct_pkg::DP_SQ_DONE: begin
            a2_ff   <= sq_round[59:28];
            term_ff <= {2'b00, a28_ff};
            sum_ff  <= '0;
         end
         sct_pkg::DP_ACCUM: begin
            if (cmd.k[0]) sum_ff <= sum_ff + $signed({4'b0000, term_ff});
            else          sum_ff <= sum_ff - $signed({4'b0000, term_ff});
         end
         sct_pkg::DP_MULT: begin
            prod_ff <= mul_a * mul_b;
         end
         sct_pkg::DP_TERM: begin
            term_ff <= q_lo;
         end
         sct_pkg::DP_SINE_DONE: begin
            if (cmd.cos_arg) c_ff <= r_val;
            else             s_ff <= r_val;
            if (cmd.final_sel) begin
               res_ff.value          <= r_val;
               res_ff.saturated      <= 1'b0;
               res_ff.divide_by_zero <= 1'b0;
            end
         end
         sct_pkg::DP_QUOT_START: begin
            qneg_ff <= num_v[31] ^ den_v[31];
            dz_ff   <= den_v == 32'sd0;
            nz_ff   <= num_v == 32'sd0;
            nneg_ff <= num_v[31];
         end
         sct_pkg::DP_QUOT_DONE: begin
            res_ff.divide_by_zero <= dz_ff;
            if (dz_ff) begin
               res_ff.saturated <= 1'b0;
               if (nz_ff)        res_ff.value <= 32'sd0;
               else if (nneg_ff) res_ff.value <= 32'sh80000000;
               else              res_ff.value <= 32'sh7FFFFFFF;
            end else if (!qneg_ff && div_quot > NW'(32'h7FFFFFFF)) begin
               res_ff.value     <= 32'sh7FFFFFFF;
               res_ff.saturated <= 1'b1;
            end else if (qneg_ff && div_quot > NW'(32'h80000000)) begin
               res_ff.value     <= 32'sh80000000;
               res_ff.saturated <= 1'b1;
            end else begin
               res_ff.value     <= qneg_ff ? -$signed(q_lo) : $signed(q_lo);
               res_ff.saturated <= 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_word = res_ff;

endmodule

>>> rtl/core/sct_ctrl.sv
// Controller: sequences reduction, series terms and the final quotient.
// Depends on sct_pkg; commands sct_datapath and holds the term count register.
module sct_ctrl #(
   parameter int MAX_TERMS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_op,
   input  logic                 csr_we,
   input  logic [3:0]           csr_wdata,
   input  sct_pkg::dp_stat_type stat,
   output sct_pkg::dp_cmd_type  cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);
   typedef enum logic [3:0] {
      S_IDLE, S_REDUCE, S_SQ_WAIT, S_ACCUM, S_MULT, S_DIV_START, S_DIV_WAIT,
      S_FINISH, S_LOAD_COS, S_QUOT, S_QUOT_WAIT, S_RESPOND
   } state_type;

   localparam logic [3:0] MAX_N = 4'(MAX_TERMS);

   state_type  state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic       pass_cos_ff, pass_cos_in;
   logic [3:0] k_ff, k_in;
   logic [3:0] term_count_ff;
   logic [3:0] n;
   logic       op_final;

   assign n        = (term_count_ff > MAX_N) ? MAX_N : term_count_ff;
   assign op_final = (op_ff == sct_pkg::OP_SINE) || (op_ff == sct_pkg::OP_COSINE);

   // Next state and datapath command
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      pass_cos_in = pass_cos_ff;
      k_in        = k_ff;
      cmd.dp_op     = sct_pkg::DP_NOP;
      cmd.from_req  = 1'b0;
      cmd.cos_arg   = pass_cos_ff;
      cmd.final_sel = op_final;
      cmd.tan_sel   = op_ff == sct_pkg::OP_TANGENT;
      cmd.k         = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in        = req_op;
               pass_cos_in  = req_op == sct_pkg::OP_COSINE;
               cmd.dp_op    = sct_pkg::DP_LOAD;
               cmd.from_req = 1'b1;
               cmd.cos_arg  = req_op == sct_pkg::OP_COSINE;
               state_in     = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (stat.x_gt_pi || stat.x_lt_neg_pi) begin
               cmd.dp_op = sct_pkg::DP_REDUCE;
            end else if (n == 4'd0 || stat.x_eq_pi) begin
               cmd.dp_op = sct_pkg::DP_CLEAR;
               state_in  = S_FINISH;
            end else begin
               cmd.dp_op = sct_pkg::DP_SQUARE;
               state_in  = S_SQ_WAIT;
            end
         end
         S_SQ_WAIT: begin
            cmd.dp_op = sct_pkg::DP_SQ_DONE;
            k_in      = 4'd1;
            state_in  = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.dp_op = sct_pkg::DP_ACCUM;
            state_in  = (k_ff < n) ? S_MULT : S_FINISH;
         end
         S_MULT: begin
            cmd.dp_op = sct_pkg::DP_MULT;
            state_in  = S_DIV_START;
         end
         S_DIV_START: begin
            cmd.dp_op = sct_pkg::DP_DIV_START;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.dp_op = sct_pkg::DP_TERM;
               k_in      = k_ff + 4'd1;
               state_in  = S_ACCUM;
            end
         end
         S_FINISH: begin
            cmd.dp_op = sct_pkg::DP_SINE_DONE;
            if (op_final) begin
               state_in = S_RESPOND;
            end else if (!pass_cos_ff) begin
               pass_cos_in = 1'b1;
               state_in    = S_LOAD_COS;
            end else begin
               state_in = S_QUOT;
            end
         end
         S_LOAD_COS: begin
            cmd.dp_op = sct_pkg::DP_LOAD;
            state_in  = S_REDUCE;
         end
         S_QUOT: begin
            cmd.dp_op = sct_pkg::DP_QUOT_START;
            state_in  = S_QUOT_WAIT;
         end
         S_QUOT_WAIT: begin
            if (stat.div_done) begin
               cmd.dp_op = sct_pkg::DP_QUOT_DONE;
               state_in  = S_RESPOND;
            end
         end
         S_RESPOND: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, sequencing registers and term count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         term_count_ff <= sct_pkg::TERM_COUNT_RESET;
         pass_cos_ff   <= 1'b0;
         op_ff         <= sct_pkg::OP_SINE;
         k_ff          <= 4'd0;
      end else begin
         state_ff    <= state_in;
         pass_cos_ff <= pass_cos_in;
         op_ff       <= op_in;
         k_ff        <= k_in;
         if (csr_we) term_count_ff <= csr_wdata;
      end
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = state_ff == S_RESPOND;

endmodule

>>> rtl/core/sine_cosine_tangent_series.sv
// Sine, cosine, tangent and cotangent of a Q7.24 angle by Maclaurin series.
// Depends on sct_pkg, sct_ctrl, sct_datapath and the assertion macro header.
//
// One word at a time: start is taken while busy is low, and the result on rsp_word
// is flagged by rsp_strobe for a single cycle; the receiver cannot stall it,
// so it must take the word in that cycle. Sine or cosine run time grows with R
// (0 to about 21), the number of 2*pi reduction steps, and with N, the clamped
// term count; each series term after the first costs one multiply plus a 52-step
// one-bit-per-cycle divide. Tangent and cotangent run the series twice with a
// reload state between, then a further divide on the same divider. The user must
// write term_count through csr_we/csr_wdata only while busy is low; the block
// itself does not enforce it.
`include "sine_cosine_tangent_series_defines.svh"

module sine_cosine_tangent_series #(
   parameter int MAX_TERMS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sct_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output sct_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic [3:0]            csr_wdata
);
   sct_pkg::dp_cmd_type  cmd;
   sct_pkg::dp_stat_type stat;

   // Sequencer
   sct_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_op     (req_word.op),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // Arithmetic
   sct_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .stat     (stat),
      .rsp_word (rsp_word)
   );

   // Checks
   `SCT_ASSERT(a_one_strobe, rsp_strobe |=> !rsp_strobe && !busy, "result strobe not single")
   `SCT_ASSERT(a_accept_busy, start && !busy |=> busy && !rsp_strobe, "accepted word not busy")
   `SCT_ASSERT(a_dz_no_sat, rsp_strobe && rsp_word.divide_by_zero |-> !rsp_word.saturated, "dz with sat")
   `SCT_ASSERT_ALWAYS(a_strobe_busy, rsp_strobe |-> busy, "strobe while idle")

endmodule
